// ===== rtl/aip_pkg.sv =====
// ----------------------------------------------------------------------------
// aip_pkg: shared types and helpers for the ASCII integer parser
// Character classes, result status codes, phase encoding and result bundle.
// ----------------------------------------------------------------------------
package aip_pkg;

	localparam int AIP_MAX_CHARS = 10;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEAD  = 3'd1,
		ST_BAD_AFTER = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_TOO_LONG  = 3'd4,
		ST_BAD_DEC   = 3'd5,
		ST_BAD_HEX   = 3'd6,
		ST_NEG_HEX   = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'b001,
		PH_DIGITS = 3'b010,
		PH_WAIT   = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		PZ_NONE = 2'd0,
		PZ_ZERO = 2'd1,
		PZ_ZX   = 2'd2
	} prefix_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [31:0] value;
		logic [3:0]  char_count;
	} res_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// hex digit value in [3:0]; bit 4 set when c is not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (is_digit(c)) begin
			t = c - 8'h30;
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			t = c - 8'h57;
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			t = c - 8'h37;
		end else begin
			t = 8'h10;
		end
		return t[4:0];
	endfunction

endpackage

// ===== rtl/aip_core.sv =====
// ----------------------------------------------------------------------------
// aip_core: parse state and per-character update
// Holds the parse state and turns one registered character into the next
// state and at most one result.
// ----------------------------------------------------------------------------
module aip_core #(
	parameter int MAX_CHARS = aip_pkg::AIP_MAX_CHARS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     ch,
	input  logic           signed_mode,
	output aip_pkg::res_t  res
);
	import aip_pkg::*;

	localparam int CNT_W = $clog2(MAX_CHARS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

	phase_t           phase_q, phase_nxt;
	logic [CNT_W-1:0] sig_count_q, sig_count_nxt;
	logic [31:0]      dec_q, dec_nxt;
	logic [31:0]      hex_q, hex_nxt;
	logic             neg_q, neg_nxt;
	prefix_t          pzx_q, pzx_nxt;
	logic             nondec_q, nondec_nxt;
	logic             badhex_q, badhex_nxt;

	logic [4:0]       hv;
	logic             c_digit;
	logic             c_space;
	logic             c_sig;
	logic [31:0]      dec_step;
	logic [CNT_W+3:0] cnt_ext;
	res_t             fin;

	assign hv       = hex_val(ch);
	assign c_digit  = is_digit(ch);
	assign c_space  = is_space(ch);
	assign c_sig    = !hv[4] || (ch == CH_LOW_X) || (ch == CH_UP_X);
	assign dec_step = (dec_q << 3) + (dec_q << 1) + {28'd0, hv[3:0]};
	assign cnt_ext  = {4'd0, sig_count_q};

	// result that closes a string in the digits phase
	always_comb begin
		fin = '0;
		fin.valid = 1'b1;
		if ((pzx_q == PZ_ZX) && (sig_count_q >= CNT_W'(3))) begin
			if (neg_q) begin
				fin.status = ST_NEG_HEX;
			end else if (badhex_q) begin
				fin.status = ST_BAD_HEX;
			end else begin
				fin.status     = ST_OK;
				fin.value      = hex_q;
				fin.char_count = cnt_ext[3:0];
			end
		end else begin
			if (nondec_q) begin
				fin.status = ST_BAD_DEC;
			end else begin
				fin.status     = ST_OK;
				fin.value      = neg_q ? (32'd0 - dec_q) : dec_q;
				fin.char_count = cnt_ext[3:0];
			end
		end
	end

	always_comb begin
		phase_nxt     = phase_q;
		sig_count_nxt = sig_count_q;
		dec_nxt       = dec_q;
		hex_nxt       = hex_q;
		neg_nxt       = neg_q;
		pzx_nxt       = pzx_q;
		nondec_nxt    = nondec_q;
		badhex_nxt    = badhex_q;
		res           = '0;
		res.status    = ST_OK;
		if (step) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (ch == CH_NUL) begin
						phase_nxt = PH_LEAD;
					end
				end
				PH_LEAD: begin
					if (ch == CH_NUL) begin
						res.valid  = 1'b1;
						res.status = ST_EMPTY;
					end else if (c_digit) begin
						phase_nxt     = PH_DIGITS;
						pzx_nxt       = (ch == CH_ZERO) ? PZ_ZERO : PZ_NONE;
						dec_nxt       = dec_step;
						sig_count_nxt = CNT_W'(1);
					end else if ((ch == CH_MINUS) && signed_mode) begin
						neg_nxt = 1'b1;
					end else if (!c_space) begin
						res.valid  = 1'b1;
						res.status = ST_BAD_LEAD;
						phase_nxt  = PH_WAIT;
					end
				end
				PH_DIGITS: begin
					if (ch == CH_NUL) begin
						res       = fin;
						phase_nxt = PH_LEAD;
					end else if (c_sig) begin
						if (sig_count_q >= CNT_MAX) begin
							res.valid  = 1'b1;
							res.status = ST_TOO_LONG;
							phase_nxt  = PH_WAIT;
						end else begin
							if (sig_count_q == CNT_W'(1)) begin
								pzx_nxt = ((pzx_q == PZ_ZERO) && (ch == CH_LOW_X)) ? PZ_ZX
									: PZ_NONE;
							end else if (hv[4]) begin
								badhex_nxt = 1'b1;
							end else begin
								hex_nxt = {hex_q[27:0], hv[3:0]};
							end
							if (c_digit) begin
								dec_nxt = dec_step;
							end else begin
								nondec_nxt = 1'b1;
							end
							sig_count_nxt = sig_count_q + CNT_W'(1);
						end
					end else if (c_space || (ch == CH_COMMA)) begin
						res       = fin;
						phase_nxt = PH_WAIT;
					end else begin
						res.valid  = 1'b1;
						res.status = ST_BAD_AFTER;
						phase_nxt  = PH_WAIT;
					end
				end
				default: begin
					phase_nxt = PH_LEAD;
				end
			endcase
			// clear the parse whenever the next phase is leading; the sign is kept while already leading
			if (phase_nxt == PH_LEAD) begin
				sig_count_nxt = '0;
				dec_nxt       = '0;
				hex_nxt       = '0;
				neg_nxt       = (phase_q == PH_LEAD) ? neg_nxt : 1'b0;
				pzx_nxt       = PZ_NONE;
				nondec_nxt    = 1'b0;
				badhex_nxt    = 1'b0;
			end
			if ((phase_q == PH_LEAD) && (ch == CH_NUL)) begin
				neg_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			sig_count_q <= '0;
			dec_q       <= '0;
			hex_q       <= '0;
			neg_q       <= 1'b0;
			pzx_q       <= PZ_NONE;
			nondec_q    <= 1'b0;
			badhex_q    <= 1'b0;
		end else begin
			phase_q     <= phase_nxt;
			sig_count_q <= sig_count_nxt;
			dec_q       <= dec_nxt;
			hex_q       <= hex_nxt;
			neg_q       <= neg_nxt;
			pzx_q       <= pzx_nxt;
			nondec_q    <= nondec_nxt;
			badhex_q    <= badhex_nxt;
		end
	end

	a_wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_q == PH_WAIT) && (ch != CH_NUL) |=> phase_q == PH_WAIT)
		else $error("parser left wait phase without NUL");

	a_nul_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		step && (ch == CH_NUL) |=> (phase_q == PH_LEAD) && (sig_count_q == '0) && !neg_q)
		else $error("NUL did not rearm the parser");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sig_count_q <= CNT_MAX)
		else $error("significant count beyond limit");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.status != ST_OK) |-> (res.value == '0) && (res.char_count == '0))
		else $error("error result carries value or count");

endmodule

// ===== rtl/ascii_integer_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_parser: streaming ASCII decimal/hex integer parser
// Feed one character per request on the input channel; a string ends at NUL.
// Each string gives one result (status, value, char_count) on the output
// channel. signed_mode is set over the config channel (cfg_ready is always
// high); write it only while no string is in progress.
// Input channel: in_valid / in_stall, payload character. A character is
// taken in any cycle where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall, payload status, value, char_count.
// A character that causes a result sits in the input register while the
// result register loads, which happens only while no result is held.
// Throughput: one character per cycle unless a result is stalled; the
// per-character update is a single shift/add step on the accumulators
// between the two registers.
// While the receiver stalls with a result pending, the block still takes
// one more character into its input register, then raises in_stall.
// Reset clears the parse state, drops any pending character and result, and
// sets signed_mode to 0.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
	parameter int MAX_CHARS = aip_pkg::AIP_MAX_CHARS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] value,
	output logic [3:0]  char_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import aip_pkg::*;

	logic       signed_mode_q;
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_free;
	logic       step;
	res_t       res;
	res_t       res_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !res_q.valid || !out_stall;
	assign step      = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			signed_mode_q <= cfg_data;
		end
	end

	// input register: load on accept, drop once consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= character;
		end
	end

	aip_core #(
		.MAX_CHARS(MAX_CHARS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.ch         (char_s1),
		.signed_mode(signed_mode_q),
		.res        (res)
	);

	// result register: advance whenever the receiver is not holding it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (out_free) begin
			res_q.valid      <= step && res.valid;
			res_q.status     <= res.status;
			res_q.value      <= res.value;
			res_q.char_count <= res.char_count;
		end
	end

	assign out_valid  = res_q.valid;
	assign status     = res_q.status;
	assign value      = res_q.value;
	assign char_count = res_q.char_count;

endmodule
